/* hdl/multilevel_priority_ready_queue_top_assert.svh */
// Assertion macros shared by the ready queue modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef MULTILEVEL_PRIORITY_READY_QUEUE_TOP_ASSERT_SVH
`define MULTILEVEL_PRIORITY_READY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MLPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MLPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mlpq_pkg.sv */
`default_nettype none

package mlpq_pkg;

  // Default configuration.
  localparam int MlpqLevels    = 60;
  localparam int MlpqRingDepth = 64;

  // Fixed field widths.
  localparam int CMD_W   = 2;
  localparam int ID_W    = 6;
  localparam int LFLD_W  = 6;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the transaction and read its level pointers
    logic commit;    // update pointers, ring and occupancy
    logic load_out;  // move the result into the output register
  } mlpq_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;  // output register holds a result that is stalled
  } mlpq_stat_t;

endpackage

`default_nettype wire

/* hdl/mlpq_ram.sv */
`default_nettype none

module mlpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/mlpq_datapath.sv */
`default_nettype none

module mlpq_datapath #(
  parameter int LEVELS     = 60,
  parameter int RING_DEPTH = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire mlpq_pkg::mlpq_ctrl_t      ctrl_i,
  output mlpq_pkg::mlpq_stat_t           stat_o,
  input  wire logic [mlpq_pkg::CMD_W-1:0]  command_i,
  input  wire logic [mlpq_pkg::ID_W-1:0]   proc_id_i,
  input  wire logic [mlpq_pkg::LFLD_W-1:0] level_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [mlpq_pkg::ID_W-1:0]      out_id_o,
  output logic                           found_o,
  output logic [mlpq_pkg::LFLD_W-1:0]    top_level_o,
  output logic                           overflow_o
);

  import mlpq_pkg::*;

  `include "multilevel_priority_ready_queue_top_assert.svh"

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int PTR_W  = 2 * SLOT_W + CNT_W;
  localparam int RA_W   = $clog2(LEVELS * RING_DEPTH);

  // Occupancy map and per-level valid bits for the pointer memory.
  logic [LEVELS-1:0] nonempty_q;
  logic [LEVELS-1:0] valid_q;

  // Captured transaction.
  logic [CMD_W-1:0] cmd_q;
  logic [ID_W-1:0]  pid_q;
  logic             lvl_ok_q;
  logic [LVL_W-1:0] lvl_addr_q;
  logic             found_q;
  logic             pvalid_q;

  // Result waiting for the output register.
  logic              res_deq_q;
  logic              res_found_q;
  logic [LFLD_W-1:0] res_top_q;
  logic              res_ovf_q;

  // Output register.
  logic              out_valid_q;
  logic [ID_W-1:0]   out_id_q;
  logic              out_found_q;
  logic [LFLD_W-1:0] out_top_q;
  logic              out_ovf_q;

  logic [LVL_W-1:0]  top_idx;
  logic              any_nonempty;
  logic [LVL_W-1:0]  ptr_raddr;
  logic [PTR_W-1:0]  ptr_rdata;
  logic [PTR_W-1:0]  ptr_word;
  logic [PTR_W-1:0]  ptr_wdata;
  logic              ptr_we;
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;
  logic [SLOT_W-1:0] head_nx;
  logic [SLOT_W-1:0] tail_nx;
  logic [CNT_W-1:0]  cnt;
  logic              full;
  logic              is_enq;
  logic              is_deq;
  logic              is_peek;
  logic              enq_go;
  logic [RA_W-1:0]   ring_base;
  logic [RA_W-1:0]   ring_waddr;
  logic [RA_W-1:0]   ring_raddr;
  logic [ID_W-1:0]   ring_rdata;

  // Priority encoder: highest level whose occupancy bit is set.
  always_comb begin
    top_idx      = '0;
    any_nonempty = |nonempty_q;
    for (int i = 0; i < LEVELS; i++) begin
      if (nonempty_q[i]) begin
        top_idx = LVL_W'(i);
      end
    end
  end

  // Enqueue addresses its own level, the others the highest occupied one.
  assign ptr_raddr = (command_i == CMD_ENQUEUE) ? LVL_W'(level_i) : top_idx;

  // Capture the transaction as it is accepted.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q      <= command_i;
      pid_q      <= proc_id_i;
      lvl_ok_q   <= (32'(level_i) < 32'(LEVELS));
      lvl_addr_q <= ptr_raddr;
      found_q    <= any_nonempty;
      pvalid_q   <= valid_q[ptr_raddr];
    end
  end

  // Head, tail and count of each level; a level never written reads as zero.
  mlpq_ram #(
    .WIDTH (PTR_W),
    .DEPTH (LEVELS)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (ptr_we),
    .waddr_i (lvl_addr_q),
    .wdata_i (ptr_wdata),
    .re_i    (ctrl_i.capture),
    .raddr_i (ptr_raddr),
    .rdata_o (ptr_rdata)
  );

  assign ptr_word = pvalid_q ? ptr_rdata : '0;
  assign head     = ptr_word[PTR_W-1 -: SLOT_W];
  assign tail     = ptr_word[CNT_W +: SLOT_W];
  assign cnt      = ptr_word[CNT_W-1:0];
  assign head_nx  = (head == SLOT_W'(RING_DEPTH - 1)) ? '0 : head + SLOT_W'(1);
  assign tail_nx  = (tail == SLOT_W'(RING_DEPTH - 1)) ? '0 : tail + SLOT_W'(1);
  assign full     = (cnt == CNT_W'(RING_DEPTH));

  // Decode what the captured transaction does to the queue.
  assign is_enq  = (cmd_q == CMD_ENQUEUE) && lvl_ok_q;
  assign is_deq  = (cmd_q == CMD_DEQUEUE) && found_q;
  assign is_peek = (cmd_q == CMD_PEEK) && found_q;
  assign enq_go  = is_enq && !full;

  assign ptr_we    = ctrl_i.commit && (enq_go || is_deq);
  assign ptr_wdata = is_deq ? {head_nx, tail, cnt - CNT_W'(1)}
                            : {head, tail_nx, cnt + CNT_W'(1)};

  // Ring entries of all levels share one memory, one row of slots per level.
  assign ring_base  = RA_W'(lvl_addr_q) * RA_W'(RING_DEPTH);
  assign ring_waddr = ring_base + RA_W'(tail);
  assign ring_raddr = ring_base + RA_W'(head);

  mlpq_ram #(
    .WIDTH (ID_W),
    .DEPTH (LEVELS * RING_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.commit && enq_go),
    .waddr_i (ring_waddr),
    .wdata_i (pid_q),
    .re_i    (ctrl_i.commit && is_deq),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  // Occupancy and pointer validity follow every committed change.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q <= '0;
      valid_q    <= '0;
    end else if (ctrl_i.commit) begin
      if (enq_go) begin
        nonempty_q[lvl_addr_q] <= 1'b1;
        valid_q[lvl_addr_q]    <= 1'b1;
      end else if (is_deq) begin
        valid_q[lvl_addr_q] <= 1'b1;
        if (cnt == CNT_W'(1)) begin
          nonempty_q[lvl_addr_q] <= 1'b0;
        end
      end
    end
  end

  // Result flags settle at commit; the dequeued id follows from the registered ring read.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      res_deq_q   <= is_deq;
      res_found_q <= is_deq || is_peek;
      res_top_q   <= (is_deq || is_peek) ? LFLD_W'(lvl_addr_q) : '0;
      res_ovf_q   <= is_enq && full;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      out_id_q    <= res_deq_q ? ring_rdata : '0;
      out_found_q <= res_found_q;
      out_top_q   <= res_top_q;
      out_ovf_q   <= res_ovf_q;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_id_o        = out_id_q;
  assign found_o         = out_found_q;
  assign top_level_o     = out_top_q;
  assign overflow_o      = out_ovf_q;

  // A level is only marked occupied after its pointers were written.
  `MLPQ_ASSERT_IMP(a_map_has_ptrs, 1'b1, (nonempty_q & ~valid_q) == '0,
                   "occupied level without written pointers")
  // An overflowed enqueue never reports a found level.
  `MLPQ_ASSERT_IMP(a_ovf_not_found, out_valid_q && out_ovf_q, !out_found_q,
                   "overflow and found reported together")
  // A nonzero id only comes out of a successful dequeue.
  `MLPQ_ASSERT_IMP(a_id_needs_found, out_valid_q && (out_id_q != '0), out_found_q,
                   "id returned without a found level")

endmodule

`default_nettype wire

/* hdl/mlpq_ctrl.sv */
`default_nettype none

module mlpq_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire mlpq_pkg::mlpq_stat_t stat_i,
  output mlpq_pkg::mlpq_ctrl_t      ctrl_o
);

  import mlpq_pkg::*;

  `include "multilevel_priority_ready_queue_top_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_PTR,
    S_OUT
  } state_e;

  state_e state_q;

  // Sequence: accept and read pointers, commit updates, hand off the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_PTR;
          end
        end
        S_PTR: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!stat_i.out_busy) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Commands decoded from the state.
  assign in_stall_o      = (state_q != S_IDLE);
  assign ctrl_o.capture  = (state_q == S_IDLE) && in_valid_i;
  assign ctrl_o.commit   = (state_q == S_PTR);
  assign ctrl_o.load_out = (state_q == S_OUT) && !stat_i.out_busy;

  `MLPQ_ASSERT_NXT(a_capture_then_ptr, ctrl_o.capture, state_q == S_PTR,
                   "accepted transaction did not move to pointer stage")
  `MLPQ_ASSERT_NXT(a_commit_then_out, ctrl_o.commit, state_q == S_OUT,
                   "commit not followed by output stage")
  `MLPQ_ASSERT_NXT(a_load_then_idle, ctrl_o.load_out, !in_stall_o,
                   "controller did not return to idle after loading result")

endmodule

`default_nettype wire

/* hdl/multilevel_priority_ready_queue_top.sv */
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    command_i, proc_id_i, level_i
// out      output     out_valid_o / out_stall_i  out_id_o, found_o, top_level_o, overflow_o
//
// A command is accepted in idle; its result enters the output register
// after a pointer memory read and a pointer and ring update.
// The input stalls until that load, so no new transaction is taken before the last result is loaded.
// A stalled output holds the controller in its last stage; the result register keeps its value.
// Reset clears the occupancy map and per-level pointer valid bits at once; no clearing pass.
`default_nettype none

module multilevel_priority_ready_queue_top #(
  parameter int LEVELS     = mlpq_pkg::MlpqLevels,
  parameter int RING_DEPTH = mlpq_pkg::MlpqRingDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [mlpq_pkg::CMD_W-1:0]  command_i,
  input  wire logic [mlpq_pkg::ID_W-1:0]   proc_id_i,
  input  wire logic [mlpq_pkg::LFLD_W-1:0] level_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [mlpq_pkg::ID_W-1:0]        out_id_o,
  output logic                             found_o,
  output logic [mlpq_pkg::LFLD_W-1:0]      top_level_o,
  output logic                             overflow_o
);

  import mlpq_pkg::*;

  mlpq_ctrl_t ctrl;
  mlpq_stat_t stat;

  // Sequencer.
  mlpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // Queue storage and result path.
  mlpq_datapath #(
    .LEVELS     (LEVELS),
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .command_i   (command_i),
    .proc_id_i   (proc_id_i),
    .level_i     (level_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_id_o    (out_id_o),
    .found_o     (found_o),
    .top_level_o (top_level_o),
    .overflow_o  (overflow_o)
  );

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import mlpq_pkg::*;

  // The spare command code does nothing and returns an all-zero transaction.
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  localparam int RandomItems = 1900;
  localparam int DirectedRows = 23;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              found;
    logic [LFLD_W-1:0] top;
    logic              ovf;
  } sched_reply_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   pid;
    logic [LFLD_W-1:0] lvl;
    logic              typed;
    sched_reply_t      want;
  } stim_row_t;

  localparam sched_reply_t NoReply = '0;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  command = CMD_ENQUEUE;
  logic [ID_W-1:0]   proc_id = '0;
  logic [LFLD_W-1:0] level = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ID_W-1:0]   out_id;
  logic              found;
  logic [LFLD_W-1:0] top_level;
  logic              overflow;

  multilevel_priority_ready_queue_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .command_i   (command),
    .proc_id_i   (proc_id),
    .level_i     (level),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_id_o    (out_id),
    .found_o     (found),
    .top_level_o (top_level),
    .overflow_o  (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the ready queue: one FIFO ring per priority level.
  logic [ID_W-1:0] ring_ids [MlpqLevels][MlpqRingDepth];
  int head_slot [MlpqLevels];
  int tail_slot [MlpqLevels];
  int held_ids  [MlpqLevels];
  int queued_total = 0;

  sched_reply_t due_replies [$];

  int errors = 0;
  int useful_sent = 0;
  int burst_left = 1;
  int n_enq = 0, n_ovf = 0, n_deq = 0, n_empty = 0, n_peek = 0, n_ignored = 0;

  // Directed rows; a set typed flag means the expected transaction is given here.
  stim_row_t directed_rows [DirectedRows] = '{
    '{CMD_DEQUEUE, 6'd0,  6'd0,  1'b1, NoReply},
    '{CMD_PEEK,    6'd0,  6'd0,  1'b1, NoReply},
    '{CMD_NOP,     6'd63, 6'd63, 1'b1, NoReply},
    '{CMD_ENQUEUE, 6'd63, 6'd59, 1'b1, NoReply},
    '{CMD_ENQUEUE, 6'd0,  6'd0,  1'b1, NoReply},
    '{CMD_ENQUEUE, 6'd42, 6'd60, 1'b1, NoReply},
    '{CMD_ENQUEUE, 6'd21, 6'd63, 1'b1, NoReply},
    '{CMD_PEEK,    6'd0,  6'd0,  1'b1, '{6'd0, 1'b1, 6'd59, 1'b0}},
    '{CMD_ENQUEUE, 6'd1,  6'd59, 1'b1, NoReply},
    '{CMD_DEQUEUE, 6'd0,  6'd0,  1'b1, '{6'd63, 1'b1, 6'd59, 1'b0}},
    '{CMD_DEQUEUE, 6'd63, 6'd63, 1'b1, '{6'd1, 1'b1, 6'd59, 1'b0}},
    '{CMD_PEEK,    6'd63, 6'd63, 1'b1, '{6'd0, 1'b1, 6'd0, 1'b0}},
    '{CMD_DEQUEUE, 6'd0,  6'd0,  1'b1, '{6'd0, 1'b1, 6'd0, 1'b0}},
    '{CMD_DEQUEUE, 6'd0,  6'd0,  1'b1, NoReply},
    '{CMD_PEEK,    6'd0,  6'd0,  1'b1, NoReply},
    '{CMD_ENQUEUE, 6'd45, 6'd30, 1'b1, NoReply},
    '{CMD_ENQUEUE, 6'd18, 6'd31, 1'b1, NoReply},
    '{CMD_ENQUEUE, 6'd5,  6'd29, 1'b1, NoReply},
    '{CMD_DEQUEUE, 6'd0,  6'd0,  1'b0, NoReply},
    '{CMD_PEEK,    6'd0,  6'd0,  1'b0, NoReply},
    '{CMD_DEQUEUE, 6'd0,  6'd0,  1'b0, NoReply},
    '{CMD_DEQUEUE, 6'd0,  6'd0,  1'b0, NoReply},
    '{CMD_NOP,     6'd0,  6'd0,  1'b1, NoReply}
  };

  // Highest level that holds an id, or -1 when every ring is empty.
  function automatic int highest_busy_level();
    for (int lv = MlpqLevels - 1; lv >= 0; lv--) begin
      if (held_ids[lv] != 0) return lv;
    end
    return -1;
  endfunction

  // Applies one command to the shadow queue and returns the transaction it yields.
  function automatic sched_reply_t schedule_step(input logic [CMD_W-1:0] cmd,
                                                 input logic [ID_W-1:0] pid,
                                                 input logic [LFLD_W-1:0] lvl);
    sched_reply_t r;
    int top;
    r = '0;
    case (cmd)
      CMD_ENQUEUE: begin
        if (lvl < MlpqLevels) begin
          if (held_ids[lvl] >= MlpqRingDepth) begin
            r.ovf = 1'b1;
          end else begin
            ring_ids[lvl][tail_slot[lvl]] = pid;
            tail_slot[lvl] = (tail_slot[lvl] + 1) % MlpqRingDepth;
            held_ids[lvl]++;
            queued_total++;
          end
        end
      end
      CMD_DEQUEUE: begin
        top = highest_busy_level();
        if (top >= 0) begin
          r.id = ring_ids[top][head_slot[top]];
          r.found = 1'b1;
          r.top = top[LFLD_W-1:0];
          head_slot[top] = (head_slot[top] + 1) % MlpqRingDepth;
          held_ids[top]--;
          queued_total--;
        end
      end
      CMD_PEEK: begin
        top = highest_busy_level();
        if (top >= 0) begin
          r.found = 1'b1;
          r.top = top[LFLD_W-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one transaction, waits for it to be taken, then idles between bursts.
  task automatic push_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] pid,
                              input logic [LFLD_W-1:0] lvl, input bit typed,
                              input sched_reply_t want);
    sched_reply_t reply;
    bit taken;
    command <= cmd;
    proc_id <= pid;
    level <= lvl;
    in_valid <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    reply = schedule_step(cmd, pid, lvl);
    due_replies.push_back(typed ? want : reply);

    // Tally what the run exercised.
    if (cmd == CMD_ENQUEUE && lvl < MlpqLevels) begin
      n_enq++;
      if (reply.ovf) n_ovf++;
    end else if (cmd == CMD_DEQUEUE) begin
      if (reply.found) n_deq++;
      else n_empty++;
    end else if (cmd == CMD_PEEK) begin
      n_peek++;
    end else begin
      n_ignored++;
    end
    if (!(cmd == CMD_NOP || (cmd == CMD_ENQUEUE && lvl >= MlpqLevels))) useful_sent++;

    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Receiver stall: a rotating 16-bit pattern, replaced at random when its hold counter runs out.
  int stall_hold = 0;
  logic [15:0] stall_bits = '0;

  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_hold <= $urandom_range(40, 300);
      case ($urandom_range(0, 3))
        0: stall_bits <= '0;
        1: stall_bits <= 16'($urandom);
        2: stall_bits <= 16'($urandom & $urandom);
        default: stall_bits <= 16'($urandom | $urandom);
      endcase
    end else begin
      stall_hold <= stall_hold - 1;
      stall_bits <= {stall_bits[0], stall_bits[15:1]};
    end
    out_stall <= stall_bits[0];
  end

  // Result checking; a transaction seen here completes at the next rising edge.
  always @(negedge clk) begin
    sched_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_replies.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual id %0d found %0d",
                 $time, out_id, found);
        $display("%0t ns: unexpected result continued, actual top %0d ovf %0d",
                 $time, top_level, overflow);
      end else begin
        want = due_replies.pop_front();
        check_field("out_id", int'(want.id), int'(out_id));
        check_field("found", int'(want.found), int'(found));
        check_field("top_level", int'(want.top), int'(top_level));
        check_field("overflow", int'(want.ovf), int'(overflow));
      end
    end
  end

  // Stimulus: reset, directed rows, then random sequences.
  initial begin
    int kind, len, lvl, hot_base, waited, r;
    bit first;
    for (int lv = 0; lv < MlpqLevels; lv++) begin
      head_slot[lv] = 0;
      tail_slot[lv] = 0;
      held_ids[lv] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      push_request(directed_rows[i].cmd, directed_rows[i].pid, directed_rows[i].lvl,
                   directed_rows[i].typed, directed_rows[i].want);
    end

    useful_sent = 0;
    first = 1'b1;
    while (useful_sent < RandomItems) begin
      kind = first ? 6 : $urandom_range(0, 9);
      if (kind <= 5) begin
        // Mixed traffic, biased toward a small window of levels so rings get deep.
        hot_base = $urandom_range(0, MlpqLevels - 4);
        len = $urandom_range(4, 40);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 45) begin
            if ($urandom_range(0, 19) == 0) lvl = $urandom_range(MlpqLevels, 63);
            else if ($urandom_range(0, 1) == 0) lvl = hot_base + $urandom_range(0, 3);
            else lvl = $urandom_range(0, MlpqLevels - 1);
            push_request(CMD_ENQUEUE, ID_W'($urandom_range(0, 63)), LFLD_W'(lvl),
                         1'b0, NoReply);
          end else if (r < 80) begin
            push_request(CMD_DEQUEUE, ID_W'($urandom_range(0, 63)),
                         LFLD_W'($urandom_range(0, 63)), 1'b0, NoReply);
          end else if (r < 95) begin
            push_request(CMD_PEEK, ID_W'($urandom_range(0, 63)),
                         LFLD_W'($urandom_range(0, 63)), 1'b0, NoReply);
          end else begin
            push_request(CMD_NOP, ID_W'($urandom_range(0, 63)),
                         LFLD_W'($urandom_range(0, 63)), 1'b0, NoReply);
          end
        end
      end else if (kind <= 7) begin
        // Fill one ring to the brim and push a few more to hit overflow.
        if (first) lvl = MlpqLevels - 1;
        else if ($urandom_range(0, 1) == 0) lvl = $urandom_range(0, 1) * (MlpqLevels - 1);
        else lvl = $urandom_range(0, MlpqLevels - 1);
        len = MlpqRingDepth - held_ids[lvl] + $urandom_range(1, 3);
        repeat (len) begin
          push_request(CMD_ENQUEUE, ID_W'($urandom_range(0, 63)), LFLD_W'(lvl),
                       1'b0, NoReply);
        end
        first = 1'b0;
      end else if (kind == 8) begin
        // Drain, running past empty now and then.
        len = (queued_total < 90) ? queued_total : $urandom_range(20, 90);
        len += $urandom_range(1, 3);
        repeat (len) begin
          if ($urandom_range(0, 7) == 0)
            push_request(CMD_PEEK, ID_W'($urandom_range(0, 63)),
                         LFLD_W'($urandom_range(0, 63)), 1'b0, NoReply);
          else
            push_request(CMD_DEQUEUE, ID_W'($urandom_range(0, 63)),
                         LFLD_W'($urandom_range(0, 63)), 1'b0, NoReply);
        end
      end else begin
        // Noise: the spare command and levels beyond the last ring.
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 0)
            push_request(CMD_NOP, ID_W'($urandom_range(0, 63)),
                         LFLD_W'($urandom_range(0, 63)), 1'b0, NoReply);
          else
            push_request(CMD_ENQUEUE, ID_W'($urandom_range(0, 63)),
                         LFLD_W'($urandom_range(MlpqLevels, 63)), 1'b0, NoReply);
        end
      end
    end
    in_valid <= 1'b0;

    // Let outstanding results arrive, then wait on for stragglers.
    waited = 0;
    while (due_replies.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    if (due_replies.size() != 0) begin
      errors += due_replies.size();
      $display("%0t ns: %0d expected results never arrived", $time, due_replies.size());
    end
    repeat (12) @(posedge clk);

    $display("Covered %0d enqueues (%0d dropped on a full ring), %0d dequeues with an id,",
             n_enq, n_ovf, n_deq);
    $display("%0d dequeues on an empty queue, %0d peeks and %0d ignored commands.",
             n_empty, n_peek, n_ignored);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(5_000_000);
    $display("Timeout: the run did not complete.");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
